// ===== hdl/tfmm_pkg.sv =====
// Shared constants and control types for the five max/min tracker.
`default_nettype none
package tfmm_pkg;
	localparam int KEEP_COUNT_DEF = 5;
	localparam int SCORE_BITS_DEF = 32;

	localparam int SCORE_W = 32;
	localparam int POS_W   = 32;
	localparam int RANK_W  = 3;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 136;

	// Per-cycle control shared by every cell of a chain.
	typedef struct packed {
		logic take;   // a word is accepted: insert it
		logic clear;  // end of set: empty the slots after this insert
		logic load;   // end of set: copy the updated slots to the drain row
		logic shift;  // a result word left: advance the drain row
	} cell_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/tfmm_cell.sv =====
// One sorted slot of the tracker with its drain-row register.
`default_nettype none
module tfmm_cell #(
	parameter int SW = 32,
	parameter bit WANT_LARGER = 1'b1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tfmm_pkg::cell_ctl_t       ctl,
	input  wire logic [SW-1:0]             new_score,
	input  wire logic [tfmm_pkg::POS_W-1:0] new_pos,
	input  wire logic                      prev_beat,
	input  wire logic [SW-1:0]             prev_score,
	input  wire logic [tfmm_pkg::POS_W-1:0] prev_pos,
	input  wire logic                      prev_fill,
	output logic                           beat,
	output logic [SW-1:0]                  score,
	output logic [tfmm_pkg::POS_W-1:0]     pos,
	output logic                           fill,
	input  wire logic [SW-1:0]             drain_score_in,
	input  wire logic [tfmm_pkg::POS_W-1:0] drain_pos_in,
	input  wire logic                      drain_fill_in,
	output logic [SW-1:0]                  drain_score,
	output logic [tfmm_pkg::POS_W-1:0]     drain_pos,
	output logic                           drain_fill
);
	import tfmm_pkg::*;

	logic [SW-1:0]    score_q, nxt_score, drain_score_q;
	logic [POS_W-1:0] pos_q, nxt_pos, drain_pos_q;
	logic             fill_q, nxt_fill, drain_fill_q;

	// Empty slots lose to any score; equal scores keep the held one.
	always_comb begin
		if (WANT_LARGER) begin
			beat = !fill_q || (new_score > score_q);
		end else begin
			beat = !fill_q || (new_score < score_q);
		end
	end

	always_comb begin
		nxt_score = score_q;
		nxt_pos   = pos_q;
		nxt_fill  = fill_q;
		if (beat) begin
			if (prev_beat) begin
				nxt_score = prev_score;
				nxt_pos   = prev_pos;
				nxt_fill  = prev_fill;
			end else begin
				nxt_score = new_score;
				nxt_pos   = new_pos;
				nxt_fill  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			pos_q   <= '0;
			fill_q  <= 1'b0;
		end else if (ctl.clear) begin
			score_q <= '0;
			pos_q   <= '0;
			fill_q  <= 1'b0;
		end else if (ctl.take) begin
			score_q <= nxt_score;
			pos_q   <= nxt_pos;
			fill_q  <= nxt_fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_score_q <= '0;
			drain_pos_q   <= '0;
			drain_fill_q  <= 1'b0;
		end else if (ctl.load) begin
			drain_score_q <= nxt_score;
			drain_pos_q   <= nxt_pos;
			drain_fill_q  <= nxt_fill;
		end else if (ctl.shift) begin
			drain_score_q <= drain_score_in;
			drain_pos_q   <= drain_pos_in;
			drain_fill_q  <= drain_fill_in;
		end
	end

	assign score       = score_q;
	assign pos         = pos_q;
	assign fill        = fill_q;
	assign drain_score = drain_score_q;
	assign drain_pos   = drain_pos_q;
	assign drain_fill  = drain_fill_q;
endmodule
`default_nettype wire

// ===== hdl/top_five_max_min_tracker_top.sv =====
// Top level of the streaming five largest / five smallest score tracker.
// Takes one score word per cycle while s_tready is high, and keeps the KEEP_COUNT
// largest and smallest scores of the current set in two rows of cells, each
// cell holding one rank and comparing the incoming score in the same cycle;
// one compare per cell plus the neighbor's shift sets the clock path. The word
// with tlast set closes the set: the next cycle the results start to leave,
// KEEP_COUNT words at one per cycle while m_tready is high, rank 0 first, tlast
// on the last rank, while the next set is already taken in. A tlast word is
// held off only while the previous set still has results waiting, so sets shorter
// than KEEP_COUNT words, or sets met by a stalled output, may see back-pressure at their end.
`default_nettype none
module top_five_max_min_tracker_top #(
	parameter int KEEP_COUNT = tfmm_pkg::KEEP_COUNT_DEF,
	parameter int SCORE_BITS = tfmm_pkg::SCORE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [tfmm_pkg::IN_DATA_W-1:0]   s_tdata,  // score[31:0]
	input  wire logic                             s_tlast,  // end_of_set
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// rank[2:0], max_score[34:3], max_position[66:35], max_valid[67],
	// min_score[99:68], min_position[131:100], min_valid[132], zero pad
	output logic [tfmm_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                  m_tlast   // final_rank
);
	import tfmm_pkg::*;

	localparam int SW    = (SCORE_BITS < SCORE_W) ? SCORE_BITS : SCORE_W;
	localparam int CNT_W = $clog2(KEEP_COUNT + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(KEEP_COUNT);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [CNT_W-1:0] left_q;
	logic [POS_W-1:0] item_pos_q;
	logic             in_fire, out_fire, set_end;
	cell_ctl_t        ctl;
	logic [SW-1:0]    new_score;

	logic [SW-1:0]    max_score_w [KEEP_COUNT];
	logic [POS_W-1:0] max_pos_w   [KEEP_COUNT];
	logic [KEEP_COUNT-1:0] max_fill_w, max_beat_w;
	logic [SW-1:0]    max_dscore_w [KEEP_COUNT];
	logic [POS_W-1:0] max_dpos_w   [KEEP_COUNT];
	logic [KEEP_COUNT-1:0] max_dfill_w;

	logic [SW-1:0]    min_score_w [KEEP_COUNT];
	logic [POS_W-1:0] min_pos_w   [KEEP_COUNT];
	logic [KEEP_COUNT-1:0] min_fill_w, min_beat_w;
	logic [SW-1:0]    min_dscore_w [KEEP_COUNT];
	logic [POS_W-1:0] min_dpos_w   [KEEP_COUNT];
	logic [KEEP_COUNT-1:0] min_dfill_w;

	logic [RANK_W-1:0] rank;

	// Hold a set end back only while the last set still has words waiting.
	assign s_tready = (left_q == '0) || !s_tlast || ((left_q == CNT_ONE) && m_tready);
	assign in_fire  = s_tvalid && s_tready;
	assign set_end  = in_fire && s_tlast;
	assign m_tvalid = (left_q != '0);
	assign out_fire = m_tvalid && m_tready;
	assign m_tlast  = (left_q == CNT_ONE);

	assign ctl.take  = in_fire;
	assign ctl.clear = set_end;
	assign ctl.load  = set_end;
	assign ctl.shift = out_fire;

	assign new_score = s_tdata[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			item_pos_q <= '0;
		end else begin
			if (set_end) begin
				left_q <= CNT_FULL;
			end else if (out_fire) begin
				left_q <= left_q - CNT_ONE;
			end
			if (set_end) begin
				item_pos_q <= '0;
			end else if (in_fire) begin
				item_pos_q <= item_pos_q + POS_W'(1);
			end
		end
	end

	for (genvar k = 0; k < KEEP_COUNT; k++) begin : g_cell
		logic             max_pbeat, min_pbeat, max_pfill, min_pfill;
		logic [SW-1:0]    max_pscore, min_pscore;
		logic [POS_W-1:0] max_ppos, min_ppos;
		logic             max_nfill, min_nfill;
		logic [SW-1:0]    max_nscore, min_nscore;
		logic [POS_W-1:0] max_npos, min_npos;

		if (k == 0) begin : g_head
			assign max_pbeat  = 1'b0;
			assign max_pscore = '0;
			assign max_ppos   = '0;
			assign max_pfill  = 1'b0;
			assign min_pbeat  = 1'b0;
			assign min_pscore = '0;
			assign min_ppos   = '0;
			assign min_pfill  = 1'b0;
		end else begin : g_link
			assign max_pbeat  = max_beat_w[k-1];
			assign max_pscore = max_score_w[k-1];
			assign max_ppos   = max_pos_w[k-1];
			assign max_pfill  = max_fill_w[k-1];
			assign min_pbeat  = min_beat_w[k-1];
			assign min_pscore = min_score_w[k-1];
			assign min_ppos   = min_pos_w[k-1];
			assign min_pfill  = min_fill_w[k-1];
		end

		// Drain rows move toward rank 0; the tail takes in empty slots.
		if (k == KEEP_COUNT - 1) begin : g_tail
			assign max_nscore = '0;
			assign max_npos   = '0;
			assign max_nfill  = 1'b0;
			assign min_nscore = '0;
			assign min_npos   = '0;
			assign min_nfill  = 1'b0;
		end else begin : g_next
			assign max_nscore = max_dscore_w[k+1];
			assign max_npos   = max_dpos_w[k+1];
			assign max_nfill  = max_dfill_w[k+1];
			assign min_nscore = min_dscore_w[k+1];
			assign min_npos   = min_dpos_w[k+1];
			assign min_nfill  = min_dfill_w[k+1];
		end

		tfmm_cell #(.SW(SW), .WANT_LARGER(1'b1)) u_max (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.new_score      (new_score),
			.new_pos        (item_pos_q),
			.prev_beat      (max_pbeat),
			.prev_score     (max_pscore),
			.prev_pos       (max_ppos),
			.prev_fill      (max_pfill),
			.beat           (max_beat_w[k]),
			.score          (max_score_w[k]),
			.pos            (max_pos_w[k]),
			.fill           (max_fill_w[k]),
			.drain_score_in (max_nscore),
			.drain_pos_in   (max_npos),
			.drain_fill_in  (max_nfill),
			.drain_score    (max_dscore_w[k]),
			.drain_pos      (max_dpos_w[k]),
			.drain_fill     (max_dfill_w[k])
		);

		tfmm_cell #(.SW(SW), .WANT_LARGER(1'b0)) u_min (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.new_score      (new_score),
			.new_pos        (item_pos_q),
			.prev_beat      (min_pbeat),
			.prev_score     (min_pscore),
			.prev_pos       (min_ppos),
			.prev_fill      (min_pfill),
			.beat           (min_beat_w[k]),
			.score          (min_score_w[k]),
			.pos            (min_pos_w[k]),
			.fill           (min_fill_w[k]),
			.drain_score_in (min_nscore),
			.drain_pos_in   (min_npos),
			.drain_fill_in  (min_nfill),
			.drain_score    (min_dscore_w[k]),
			.drain_pos      (min_dpos_w[k]),
			.drain_fill     (min_dfill_w[k])
		);
	end

	assign rank = RANK_W'(CNT_FULL - left_q);

	assign m_tdata = {
		3'b000,
		min_dfill_w[0],
		min_dpos_w[0],
		SCORE_W'(min_dscore_w[0]),
		max_dfill_w[0],
		max_dpos_w[0],
		SCORE_W'(max_dscore_w[0]),
		rank
	};

`ifndef SYNTHESIS
	// A closed set starts delivering in the next cycle.
	a_set_end_out: assert property (@(posedge clk) disable iff (!arst_n)
		set_end |=> m_tvalid)
		else $error("results did not start after set end");

	// Filled slots always form a prefix from rank 0.
	a_max_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((max_fill_w & (max_fill_w + KEEP_COUNT'(1))) == '0))
		else $error("max slots not packed from rank 0");

	a_min_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((min_fill_w & (min_fill_w + KEEP_COUNT'(1))) == '0))
		else $error("min slots not packed from rank 0");

	// After the final rank leaves with no new set closing, go idle.
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_tlast && !set_end) |=> !m_tvalid)
		else $error("output still valid after final rank");
`endif
endmodule
`default_nettype wire

// ===== dv/tb_top_five_max_min_tracker_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the streaming five largest / five smallest score tracker.
module tb_top_five_max_min_tracker_top;
	localparam int KEEP    = tfmm_pkg::KEEP_COUNT_DEF;
	localparam int MAX_ROW = 0;
	localparam int MIN_ROW = 1;
	localparam int RANDOM_WORDS = 170;

	typedef struct {
		logic [31:0] score;
		logic        eos;
		bit          tight;
	} score_word_t;

	typedef struct {
		logic [31:0] score;
		logic [31:0] pos;
		logic        filled;
	} slot_t;

	typedef struct {
		logic [2:0]  rank;
		logic [31:0] max_score;
		logic [31:0] max_pos;
		logic        max_valid;
		logic [31:0] min_score;
		logic [31:0] min_pos;
		logic        min_valid;
		logic        final_rank;
	} rank_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [tfmm_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [tfmm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;

	score_word_t score_words[$];
	rank_result_t rank_results_due[$];
	slot_t rows[2][KEEP];
	logic [31:0] stream_pos = '0;

	int errors = 0;
	int words_taken = 0;
	int results_seen = 0;
	int sets_built = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	bit cur_tight = 1'b0;
	logic hold_rx = 1'b0;

	top_five_max_min_tracker_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	function automatic void clear_rows();
		for (int r = 0; r < 2; r++) begin
			for (int k = 0; k < KEEP; k++) begin
				rows[r][k] = '{score: '0, pos: '0, filled: 1'b0};
			end
		end
		stream_pos = '0;
	endfunction

	// Strict compare: an equal score lands below the one already held.
	function automatic void place_score(int row, logic [31:0] sc, logic [31:0] pos);
		int k;
		k = 0;
		while (k < KEEP && rows[row][k].filled &&
				!(row == MAX_ROW ? (sc > rows[row][k].score) : (sc < rows[row][k].score)))
			k++;
		if (k < KEEP) begin
			for (int j = KEEP - 1; j > k; j--)
				rows[row][j] = rows[row][j - 1];
			rows[row][k] = '{score: sc, pos: pos, filled: 1'b1};
		end
	endfunction

	function automatic void track_score(logic [31:0] sc, logic eos);
		rank_result_t res;
		place_score(MAX_ROW, sc, stream_pos);
		place_score(MIN_ROW, sc, stream_pos);
		stream_pos = stream_pos + 32'd1;
		if (eos) begin
			for (int r = 0; r < KEEP; r++) begin
				res.rank       = r[2:0];
				res.max_score  = rows[MAX_ROW][r].score;
				res.max_pos    = rows[MAX_ROW][r].pos;
				res.max_valid  = rows[MAX_ROW][r].filled;
				res.min_score  = rows[MIN_ROW][r].score;
				res.min_pos    = rows[MIN_ROW][r].pos;
				res.min_valid  = rows[MIN_ROW][r].filled;
				res.final_rank = (r == KEEP - 1);
				rank_results_due.push_back(res);
			end
			clear_rows();
		end
	endfunction

	function automatic bit field_matches(string what, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, seen);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic check_rank_word();
		rank_result_t want;
		bit ok;
		if (rank_results_due.size() == 0) begin
			$display("%0t: result word with none expected: expected nothing, actual %h",
				$time, m_tdata);
			errors++;
			return;
		end
		want = rank_results_due.pop_front();
		ok = 1'b1;
		ok &= field_matches("rank", 32'(want.rank), 32'(m_tdata[2:0]));
		ok &= field_matches("max_score", want.max_score, m_tdata[34:3]);
		ok &= field_matches("max_position", want.max_pos, m_tdata[66:35]);
		ok &= field_matches("max_valid", 32'(want.max_valid), 32'(m_tdata[67]));
		ok &= field_matches("min_score", want.min_score, m_tdata[99:68]);
		ok &= field_matches("min_position", want.min_pos, m_tdata[131:100]);
		ok &= field_matches("min_valid", 32'(want.min_valid), 32'(m_tdata[132]));
		ok &= field_matches("final_rank", 32'(want.final_rank), 32'(m_tlast));
		if (!ok)
			errors++;
	endtask

	// Driver: offer one word at a time, idle a random gap after each, none in tight sets or during hold_rx.
	always @(posedge clk) begin
		score_word_t w;
		bit done;
		if (arst_n) begin
			done = s_tvalid && s_tready;
			if (done) begin
				track_score(s_tdata, s_tlast);
				words_taken++;
				tx_gap = (cur_tight || hold_rx) ? 0 : $urandom_range(0, 9);
			end
			if (!s_tvalid || done) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (score_words.size() > 0) begin
					w = score_words.pop_front();
					cur_tight = w.tight;
					s_tdata <= w.score;
					s_tlast <= w.eos;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result word, then stall a random gap, none after results 40 to 79; hold_rx also stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				check_rank_word();
				results_seen++;
				rx_gap = (results_seen >= 40 && results_seen < 80) ? 0 : $urandom_range(0, 9);
			end
			if (hold_rx) begin
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off while the sender keeps streaming: fills the drain path.
	initial begin
		while (words_taken < 90)
			@(negedge clk);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (120) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void push_word(logic [31:0] sc, logic eos, bit tight = 1'b0);
		score_words.push_back('{score: sc, eos: eos, tight: tight});
		if (eos)
			sets_built++;
	endfunction

	function automatic logic [31:0] draw_score(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($urandom_range(0, 7));
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h0000_0001;
					3: return 32'hFFFF_FFFE;
					default: return $urandom();
				endcase
			end
			default: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom())};
		endcase
	endfunction

	initial begin
		int len;
		int mode;
		int made;
		bit tight;

		clear_rows();

		// Single-word sets at both extremes; lower ranks stay empty.
		push_word(32'h0000_0000, 1'b1);
		push_word(32'hFFFF_FFFF, 1'b1);
		// Equal scores: earlier word keeps the better rank.
		push_word(32'd5, 1'b0);
		push_word(32'd5, 1'b0);
		push_word(32'd5, 1'b1);
		// Extremes mixed, more words than slots, duplicate zero.
		push_word(32'h0000_0000, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'h0000_0001, 1'b0);
		push_word(32'hFFFF_FFFE, 1'b0);
		push_word(32'h8000_0000, 1'b0);
		push_word(32'h7FFF_FFFF, 1'b0);
		push_word(32'h0000_0000, 1'b1);
		// Five words descending, then six ascending: all shifts on one side.
		for (int i = 5; i >= 1; i--)
			push_word(32'(i * 10), i == 1);
		for (int i = 1; i <= 6; i++)
			push_word(32'(i), i == 6);

		made = 0;
		while (made < RANDOM_WORDS) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			mode = $urandom_range(0, 3);
			tight = (sets_built >= 12 && sets_built < 16);
			for (int i = 0; i < len; i++)
				push_word(draw_score(mode), i == len - 1, tight);
			made += len;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (score_words.size() != 0 || s_tvalid || rank_results_due.size() != 0)
			@(negedge clk);
		repeat (4 * KEEP + 10) @(posedge clk);

		$display("Streamed %0d score words in %0d sets; %0d rank results compared.",
			words_taken, sets_built, results_seen);
		$display("Sets covered single words, ties, extremes and long runs, with output held off.");
		if (errors == 0 && rank_results_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
